// ===== sv/cami_pkg.sv =====
// ----------------------------------------------------------------------------
// cami_pkg
// Shared types and constants for the card access machine interlock.
// ----------------------------------------------------------------------------
`default_nettype none

package cami_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int FILT_W        = 16;
    localparam int FAIL_W        = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_MUST_STAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_CHECK_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FILTER_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_FILTER_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT       = 3'd5;

    // reset values of the configuration registers
    localparam logic              RST_CARD_MUST_STAY  = 1'b1;
    localparam logic              RST_SERVER_CHECK_EN = 1'b0;
    localparam logic [FILT_W-1:0] RST_STOP_FILTER_MS  = 16'd100;
    localparam logic [FILT_W-1:0] RST_CARD_FILTER_MS  = 16'd3000;
    localparam logic [FILT_W-1:0] RST_CHECK_INTERVAL  = 16'd2000;
    localparam logic [FAIL_W-1:0] RST_FAIL_LIMIT      = 6'd40;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_RUN     = 2'd2,
        MODE_RESET   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_PASS = 2'd1,
        CHK_FAIL = 2'd2
    } t_check_event;

    typedef struct packed {
        logic              card_must_stay;
        logic              server_check_en;
        logic [FILT_W-1:0] stop_filter_ms;
        logic [FILT_W-1:0] card_filter_ms;
        logic [FILT_W-1:0] check_interval_ms;
        logic [FAIL_W-1:0] fail_limit;
    } t_cfg;

    typedef struct packed {
        logic card_present;
        logic stop_pressed;
        logic auth_ok;
        logic check_ok;
    } t_poll;

    typedef struct packed {
        t_mode             mode_now;
        logic              relay_on;
        logic              led_red;
        logic              led_amber;
        logic              led_go;
        t_check_event      check_event;
        logic [FAIL_W-1:0] fail_tally;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/cami_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cami_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module cami_cfg_regs import cami_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.card_must_stay    <= RST_CARD_MUST_STAY;
            r_cfg.server_check_en   <= RST_SERVER_CHECK_EN;
            r_cfg.stop_filter_ms    <= RST_STOP_FILTER_MS;
            r_cfg.card_filter_ms    <= RST_CARD_FILTER_MS;
            r_cfg.check_interval_ms <= RST_CHECK_INTERVAL;
            r_cfg.fail_limit        <= RST_FAIL_LIMIT;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_CARD_MUST_STAY:  r_cfg.card_must_stay    <= i_wr_data[0];
                CFG_SERVER_CHECK_EN: r_cfg.server_check_en   <= i_wr_data[0];
                CFG_STOP_FILTER_MS:  r_cfg.stop_filter_ms    <= i_wr_data[FILT_W-1:0];
                CFG_CARD_FILTER_MS:  r_cfg.card_filter_ms    <= i_wr_data[FILT_W-1:0];
                CFG_CHECK_INTERVAL:  r_cfg.check_interval_ms <= i_wr_data[FILT_W-1:0];
                CFG_FAIL_LIMIT:      r_cfg.fail_limit        <= i_wr_data[FAIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/cami_core.sv =====
// ----------------------------------------------------------------------------
// cami_core
// Interlock state machine with server check, stop and card absence timers.
// ----------------------------------------------------------------------------
`default_nettype none

module cami_core import cami_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire t_cfg                 i_cfg,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire t_poll                i_poll,
    output t_mode                     o_mode,
    output t_result                   o_result
);

    t_mode               r_mode,         n_mode;
    logic [TIME_BITS-1:0] r_last_check,  n_last_check;
    logic [FAIL_W-1:0]    r_fail,        n_fail;
    logic                 r_stop_timing, n_stop_timing;
    logic [TIME_BITS-1:0] r_stop_start,  n_stop_start;
    logic                 r_abs_timing,  n_abs_timing;
    logic [TIME_BITS-1:0] r_abs_start,   n_abs_start;

    logic [TIME_BITS-1:0] w_el_check;
    logic [TIME_BITS-1:0] w_el_stop;
    logic [TIME_BITS-1:0] w_el_abs;
    logic                 w_check_due;
    logic                 w_fail_trip;
    logic                 w_stop_trip;
    logic                 w_abs_trip;
    t_check_event         w_event;

    // wrapping differences; a timer that starts on this poll has zero elapsed
    assign w_el_check  = i_now - r_last_check;
    assign w_el_stop   = r_stop_timing ? (i_now - r_stop_start) : '0;
    assign w_el_abs    = r_abs_timing  ? (i_now - r_abs_start)  : '0;
    assign w_check_due = i_cfg.server_check_en
                       && (w_el_check >= TIME_BITS'(i_cfg.check_interval_ms));

    // datapath: timers, check tally
    always_comb begin
        n_last_check  = r_last_check;
        n_fail        = r_fail;
        n_stop_timing = r_stop_timing;
        n_stop_start  = r_stop_start;
        n_abs_timing  = r_abs_timing;
        n_abs_start   = r_abs_start;
        w_event       = CHK_NONE;
        w_fail_trip   = 1'b0;
        w_stop_trip   = 1'b0;
        w_abs_trip    = 1'b0;
        case (r_mode)
            MODE_IDENT: begin
                if (i_poll.auth_ok) begin
                    n_fail       = '0;
                    n_last_check = i_now;
                end
            end
            MODE_RUN: begin
                if (i_cfg.card_must_stay) begin
                    if (w_check_due) begin
                        n_last_check = i_now;
                        if (i_poll.check_ok) begin
                            n_fail  = '0;
                            w_event = CHK_PASS;
                        end else begin
                            n_fail      = (r_fail != '1) ? r_fail + FAIL_W'(1) : r_fail;
                            w_event     = CHK_FAIL;
                            w_fail_trip = (n_fail >= i_cfg.fail_limit);
                        end
                    end
                    if (i_poll.stop_pressed) begin
                        n_stop_timing = 1'b1;
                        if (!r_stop_timing) begin
                            n_stop_start = i_now;
                        end
                        w_stop_trip = (w_el_stop >= TIME_BITS'(i_cfg.stop_filter_ms));
                    end else begin
                        n_stop_timing = 1'b0;
                    end
                    if (!i_poll.card_present) begin
                        n_abs_timing = 1'b1;
                        if (!r_abs_timing) begin
                            n_abs_start = i_now;
                        end
                        w_abs_trip = (w_el_abs >= TIME_BITS'(i_cfg.card_filter_ms));
                    end else begin
                        n_abs_timing = 1'b0;
                    end
                end
            end
            MODE_RESET: begin
                n_fail = '0;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_STANDBY: begin
                if (i_poll.card_present) begin
                    n_mode = MODE_IDENT;
                end
            end
            MODE_IDENT: begin
                n_mode = i_poll.auth_ok ? MODE_RUN : MODE_RESET;
            end
            MODE_RUN: begin
                if (i_cfg.card_must_stay) begin
                    if (w_fail_trip || w_stop_trip || w_abs_trip) begin
                        n_mode = MODE_RESET;
                    end
                end else if (i_poll.stop_pressed) begin
                    n_mode = MODE_RESET;
                end
            end
            MODE_RESET: begin
                if (!i_poll.card_present && !i_poll.stop_pressed) begin
                    n_mode = MODE_STANDBY;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    // outputs follow the new state
    always_comb begin
        o_result.mode_now    = n_mode;
        o_result.relay_on    = 1'b0;
        o_result.led_red     = 1'b0;
        o_result.led_amber   = 1'b0;
        o_result.led_go      = 1'b0;
        o_result.check_event = w_event;
        o_result.fail_tally  = n_fail;
        case (n_mode)
            MODE_STANDBY: o_result.led_amber = 1'b1;
            MODE_IDENT: begin
                o_result.led_amber = 1'b1;
                o_result.led_go    = 1'b1;
            end
            MODE_RUN: begin
                o_result.relay_on = 1'b1;
                o_result.led_go   = 1'b1;
            end
            MODE_RESET: o_result.led_red = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STANDBY;
            r_last_check  <= '0;
            r_fail        <= '0;
            r_stop_timing <= 1'b0;
            r_stop_start  <= '0;
            r_abs_timing  <= 1'b0;
            r_abs_start   <= '0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_last_check  <= n_last_check;
            r_fail        <= n_fail;
            r_stop_timing <= n_stop_timing;
            r_stop_start  <= n_stop_start;
            r_abs_timing  <= n_abs_timing;
            r_abs_start   <= n_abs_start;
        end
    end

    assign o_mode = r_mode;

endmodule

`default_nettype wire

// ===== sv/card_access_machine_interlock_top.sv =====
// ----------------------------------------------------------------------------
// card_access_machine_interlock_top
// Card access machine interlock: one poll in, one result out.
// ----------------------------------------------------------------------------
// Path: a poll accepted into the input register is evaluated against the
//   interlock state and lands in the result register while output is not stalled.
// Throughput: one poll per cycle while output is not stalled; the state update
//   is one compare-and-subtract pass between the input and result registers.
// Reset: synchronous, active low; state to standby, timers and tally cleared,
//   configuration to its defaults, both pipeline stages empty.
`default_nettype none

module card_access_machine_interlock_top import cami_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // poll channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [NOW_W-1:0]      i_now_ms,
    input  wire logic                  i_card_present,
    input  wire logic                  i_stop_pressed,
    input  wire logic                  i_auth_ok,
    input  wire logic                  i_check_ok,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_mode_now,
    output logic                       o_relay_on,
    output logic                       o_led_red,
    output logic                       o_led_amber,
    output logic                       o_led_go,
    output logic [1:0]                 o_check_event,
    output logic [FAIL_W-1:0]          o_fail_tally,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                 w_cfg;
    logic                 r_in_valid;
    logic [NOW_W-1:0]     r_now_ms;
    t_poll                r_poll;
    logic [TIME_BITS-1:0] w_now;
    logic                 r_out_valid;
    t_result              r_result;
    t_result              w_result;
    t_mode                w_mode;
    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_in_free;

    assign o_cfg_ready = 1'b1;

    cami_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_in_free  = !r_in_valid || w_fire;
    assign o_in_stall = !w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_in_valid) begin
            r_now_ms            <= i_now_ms;
            r_poll.card_present <= i_card_present;
            r_poll.stop_pressed <= i_stop_pressed;
            r_poll.auth_ok      <= i_auth_ok;
            r_poll.check_ok     <= i_check_ok;
        end
    end

    // timestamp held in TIME_BITS bits
    assign w_now = TIME_BITS'(r_now_ms);

    cami_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_cfg    (w_cfg),
        .i_now    (w_now),
        .i_poll   (r_poll),
        .o_mode   (w_mode),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode_now    = r_result.mode_now;
    assign o_relay_on    = r_result.relay_on;
    assign o_led_red     = r_result.led_red;
    assign o_led_amber   = r_result.led_amber;
    assign o_led_go      = r_result.led_go;
    assign o_check_event = r_result.check_event;
    assign o_fail_tally  = r_result.fail_tally;

    // interlock state moves only when a poll is evaluated
    a_mode_moves_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(w_mode))
        else $error("interlock state changed without a poll");

    // a server check only happens while running, leaving running or reset
    a_check_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_check_event != CHK_NONE)
        |-> (o_mode_now == MODE_RUN) || (o_mode_now == MODE_RESET))
        else $error("check event outside running");

    // a passed check clears the failure tally
    a_pass_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_check_event == CHK_PASS) |-> (o_fail_tally == '0))
        else $error("tally not cleared by passed check");

    // relay only with the running state
    a_relay_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_relay_on == (o_mode_now == MODE_RUN)))
        else $error("relay does not match running state");

endmodule

`default_nettype wire
